>>> sv/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types and constants for the button debounce and press classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bdpc_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int NOW_W          = 32;
  localparam int CFG_MS_W       = 16;
  localparam int COUNT_W        = 8;
  localparam int APB_ADDR_W     = 4;
  localparam int APB_DATA_W     = 32;

  localparam logic                UNPRESSED_RST = 1'b1;
  localparam logic [CFG_MS_W-1:0] DEBOUNCE_RST  = 16'd50;
  localparam logic [CFG_MS_W-1:0] MULTI_RST     = 16'd500;
  localparam logic [CFG_MS_W-1:0] LONG_RST      = 16'd1000;

  typedef enum logic [1:0] {
    EDGE_NONE    = 2'd0,
    EDGE_PRESS   = 2'd1,
    EDGE_RELEASE = 2'd2
  } edge_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_SHORT = 2'd1,
    KIND_LONG  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_UNPRESSED = 2'd0,
    REG_DEBOUNCE  = 2'd1,
    REG_MULTI     = 2'd2,
    REG_LONG      = 2'd3
  } reg_idx_t;

endpackage

`default_nettype wire

>>> sv/bdpc_if.sv
// ----------------------------------------------------------------------------
// bdpc_if
// Valid/ready channels for pin samples and classified results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdpc_in_if;
  logic        valid;
  logic        ready;
  logic        pin_level;
  logic [31:0] now_ms;

  modport source (output valid, output pin_level, output now_ms, input ready);
  modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

interface bdpc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] edge_event;
  logic [1:0] press_kind;
  logic [7:0] click_count;

  modport source (output valid, output edge_event, output press_kind,
                  output click_count, input ready);
  modport sink   (input valid, input edge_event, input press_kind,
                  input click_count, output ready);
endinterface

`default_nettype wire

>>> sv/button_debounce_press_classifier.sv
// ----------------------------------------------------------------------------
// button_debounce_press_classifier
// Debounces a polled button pin, reports press/release edges, classes each
// release as short or long and counts series of short presses.
//
//   channel  | dir | payload                                | beat
//   ---------+-----+----------------------------------------+-----------------
//   sample   | in  | pin_level, now_ms                      | valid & ready
//   result   | out | edge_event, press_kind, click_count    | valid & ready
//   apb      | in  | paddr, pwdata (4 registers at 4*i)     | psel&penable&pwrite
//
// One result beat per sample beat, one beat per cycle sustained while result is ready.
// A sample passes through an input register, then the classifier logic into
// the result register, where all button state is updated.
// A stalled result still lets one more sample into the input register.
// rst is synchronous: clears state (but last_level), valids and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_press_classifier #(
  parameter int TIME_WIDTH = bdpc_pkg::TIME_WIDTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  bdpc_in_if.sink                             sample,
  bdpc_out_if.source                          result,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [bdpc_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire  [bdpc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [bdpc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  import bdpc_pkg::*;

  // configuration
  logic                unpressed_level;
  logic [CFG_MS_W-1:0] debounce_ms;
  logic [CFG_MS_W-1:0] multi_press_ms;
  logic [CFG_MS_W-1:0] long_press_ms;
  reg_idx_t            reg_idx;
  logic                cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      unpressed_level <= UNPRESSED_RST;
      debounce_ms     <= DEBOUNCE_RST;
      multi_press_ms  <= MULTI_RST;
      long_press_ms   <= LONG_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_UNPRESSED: unpressed_level <= pwdata[0];
        REG_DEBOUNCE:  debounce_ms     <= pwdata[CFG_MS_W-1:0];
        REG_MULTI:     multi_press_ms  <= pwdata[CFG_MS_W-1:0];
        REG_LONG:      long_press_ms   <= pwdata[CFG_MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_UNPRESSED: prdata[0]            = unpressed_level;
      REG_DEBOUNCE:  prdata[CFG_MS_W-1:0] = debounce_ms;
      REG_MULTI:     prdata[CFG_MS_W-1:0] = multi_press_ms;
      REG_LONG:      prdata[CFG_MS_W-1:0] = long_press_ms;
      default:       prdata               = '0;
    endcase
  end

  // handshake
  logic in_valid;
  logic in_pin;
  logic [TIME_WIDTH-1:0] in_now;
  logic [TIME_WIDTH+NOW_W-1:0] now_ext;
  logic out_load;
  logic in_load;

  assign out_load     = in_valid && (!result.valid || result.ready);
  assign sample.ready = !in_valid || out_load;
  assign in_load      = sample.valid && sample.ready;
  assign now_ext      = {{TIME_WIDTH{1'b0}}, sample.now_ms};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_pin <= sample.pin_level;
      in_now <= now_ext[TIME_WIDTH-1:0];
    end
  end

  // button state
  logic                  debouncing;
  logic                  held;
  logic [TIME_WIDTH-1:0] debounce_ref_time;
  logic                  last_level;
  logic [TIME_WIDTH-1:0] press_start_time;
  logic [TIME_WIDTH-1:0] window_ref_time;
  logic [COUNT_W-1:0]    short_count;

  logic                  debouncing_next;
  logic                  held_next;
  logic [TIME_WIDTH-1:0] debounce_ref_time_next;
  logic                  last_level_next;
  logic [TIME_WIDTH-1:0] press_start_time_next;
  logic [TIME_WIDTH-1:0] window_ref_time_next;
  logic [COUNT_W-1:0]    short_count_next;

  logic [TIME_WIDTH-1:0] el_deb;
  logic [TIME_WIDTH-1:0] el_press;
  logic [TIME_WIDTH-1:0] el_win;
  logic [TIME_WIDTH-1:0] deb_lim;
  logic [TIME_WIDTH-1:0] multi_lim;
  logic [TIME_WIDTH-1:0] long_lim;
  logic [COUNT_W-1:0]    count_inc;

  edge_t              edge_ev;
  kind_t              kind;
  logic [COUNT_W-1:0] count_out;

  assign el_deb    = in_now - debounce_ref_time;
  assign el_press  = in_now - press_start_time;
  assign el_win    = in_now - window_ref_time;
  assign deb_lim   = TIME_WIDTH'(debounce_ms);
  assign multi_lim = TIME_WIDTH'(multi_press_ms);
  assign long_lim  = TIME_WIDTH'(long_press_ms);
  assign count_inc = short_count + COUNT_W'(1);

  always_comb begin
    debouncing_next        = debouncing;
    held_next              = held;
    debounce_ref_time_next = debounce_ref_time;
    last_level_next        = last_level;
    press_start_time_next  = press_start_time;
    window_ref_time_next   = window_ref_time;
    short_count_next       = short_count;
    edge_ev                = EDGE_NONE;
    kind                   = KIND_NONE;
    count_out              = '0;

    if (debouncing) begin
      if (in_pin != last_level) begin
        debounce_ref_time_next = in_now;
      end else if (el_deb >= deb_lim) begin
        debouncing_next = 1'b0;
      end
      last_level_next = in_pin;
    end else begin
      if (!held && in_pin != unpressed_level) begin
        edge_ev   = EDGE_PRESS;
        held_next = 1'b1;
      end else if (held && in_pin == unpressed_level) begin
        edge_ev   = EDGE_RELEASE;
        held_next = 1'b0;
      end
      if (edge_ev != EDGE_NONE) begin
        debouncing_next        = 1'b1;
        debounce_ref_time_next = in_now;
        last_level_next        = in_pin;
      end
    end

    if (edge_ev == EDGE_PRESS) begin
      press_start_time_next = in_now;
    end else if (edge_ev == EDGE_RELEASE) begin
      kind                  = (el_press >= long_lim) ? KIND_LONG : KIND_SHORT;
      press_start_time_next = in_now;
    end

    if (kind == KIND_SHORT) begin
      if (short_count == '0 || el_win <= multi_lim) begin
        short_count_next     = count_inc;
        count_out            = count_inc;
        window_ref_time_next = in_now;
      end else begin
        short_count_next = '0;
      end
    end else if (el_win > multi_lim) begin
      short_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debouncing        <= 1'b0;
      held              <= 1'b0;
      debounce_ref_time <= '0;
      press_start_time  <= '0;
      window_ref_time   <= '0;
      short_count       <= '0;
    end else if (out_load) begin
      debouncing        <= debouncing_next;
      held              <= held_next;
      debounce_ref_time <= debounce_ref_time_next;
      press_start_time  <= press_start_time_next;
      window_ref_time   <= window_ref_time_next;
      short_count       <= short_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      last_level <= last_level_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (!result.valid || result.ready) begin
      result.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.edge_event  <= edge_ev;
      result.press_kind  <= kind;
      result.click_count <= count_out;
    end
  end

endmodule

`default_nettype wire
